@@ hw/rtl/deace_pkg.sv @@
// Shared types, object indexes and drive state decoding for the drive enable enforcer.
package deace_pkg;

    // CiA 402 drive states in classification order
    typedef enum logic [2:0] {
        CODE_NRTSO = 3'd0,
        CODE_QSA   = 3'd1,
        CODE_FRA   = 3'd2,
        CODE_RTSO  = 3'd3,
        CODE_SO    = 3'd4,
        CODE_OE    = 3'd5,
        CODE_SOD   = 3'd6,
        CODE_F     = 3'd7
    } t_code;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_VEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_ACC = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_OFFSET = 2'd3;

    localparam logic [6:0]  NODE_ID_RESET = 7'd112;
    localparam logic [10:0] SDO_RESP_BASE = 11'h580;

    // SDO command specifiers
    localparam logic [7:0] CS_WRITE_ACK = 8'h60;
    localparam logic [7:0] CS_ABORT     = 8'h80;
    localparam logic [7:0] CS_UPLOAD_1  = 8'h4F;
    localparam logic [7:0] CS_UPLOAD_2  = 8'h4B;
    localparam logic [7:0] CS_UPLOAD_3  = 8'h47;
    localparam logic [7:0] CS_UPLOAD_4  = 8'h43;

    // Object indexes
    localparam logic [15:0] OBJ_CONTROL_WORD  = 16'h6040;
    localparam logic [15:0] OBJ_STATUS_WORD   = 16'h6041;
    localparam logic [15:0] OBJ_POSITION      = 16'h6064;
    localparam logic [15:0] OBJ_HOME_OFFSET   = 16'h607C;
    localparam logic [15:0] OBJ_MOTION_PROF   = 16'h6086;
    localparam logic [15:0] OBJ_END_VELOCITY  = 16'h6082;
    localparam logic [15:0] OBJ_PROFILE_VEL   = 16'h6081;
    localparam logic [15:0] OBJ_PROFILE_ACC   = 16'h6083;
    localparam logic [15:0] OBJ_PROFILE_DEC   = 16'h6084;
    localparam logic [15:0] OBJ_QSTOP_DEC     = 16'h6085;
    localparam logic [15:0] OBJ_MAX_ACC       = 16'h60C5;
    localparam logic [15:0] OBJ_MAX_DEC       = 16'h60C6;
    localparam logic [15:0] OBJ_OP_MODE       = 16'h6060;

    localparam logic [7:0] OP_MODE_PROFILE_POS = 8'd1;

    localparam logic [2:0] WR_BYTES_CTRL = 3'd2;
    localparam logic [2:0] WR_BYTES_WORD = 3'd4;

    // Status word masks and patterns; only the low byte takes part
    localparam logic [7:0] CLS_MASK [8] = '{8'h4F, 8'h6F, 8'h4F, 8'h6F,
                                            8'h6F, 8'h6F, 8'h4F, 8'h4F};
    localparam logic [7:0] CLS_ID   [8] = '{8'h00, 8'h07, 8'h0F, 8'h21,
                                            8'h23, 8'h27, 8'h40, 8'h48};

    typedef struct packed {
        logic [6:0]  node_id;
        logic [31:0] prof_vel;
        logic [31:0] prof_acc;
        logic [31:0] home_offset_target;
    } t_cfg;

    typedef struct packed {
        logic [10:0] can_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
        logic        drive_enable;
        logic        shutdown_request;
    } t_frame;

    typedef struct packed {
        t_code current_code;
        t_code target_code;
        logic  shutdown_latched;
    } t_state;

    typedef struct packed {
        logic        send_write;
        logic [15:0] write_object;
        logic [31:0] write_value;
        logic [2:0]  write_bytes;
        t_code       drive_state;
        logic        encoder_valid;
        logic [31:0] encoder_value;
        logic        shutdown_done;
    } t_result;

    // First match in state order, fault when nothing matches
    function automatic t_code classify(logic [7:0] sw);
        t_code c;
        c = CODE_F;
        for (int k = 7; k >= 0; k--) begin
            if ((sw & CLS_MASK[k]) == CLS_ID[k]) begin
                c = t_code'(k[2:0]);
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] cw_for_state(t_code c);
        logic [15:0] w;
        case (c)
            CODE_RTSO: w = 16'd6;
            CODE_SO:   w = 16'd7;
            CODE_OE:   w = 16'd15;
            default:   w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/deace_step.sv @@
// Frame decode, drive state sequencing and write request selection for one response frame.
module deace_step (
    input  deace_pkg::t_cfg    i_cfg,
    input  deace_pkg::t_frame  i_frame,
    input  deace_pkg::t_state  i_state,
    output deace_pkg::t_state  o_state,
    output deace_pkg::t_result o_result
);

    logic              latched;
    logic              match;
    logic [10:0]       resp_id;
    logic [15:0]       obj;
    logic [31:0]       data;
    deace_pkg::t_code  cur;
    deace_pkg::t_code  tgt;
    logic              is_acc_obj;

    assign latched = i_state.shutdown_latched | i_frame.shutdown_request;
    assign resp_id = deace_pkg::SDO_RESP_BASE + {4'd0, i_cfg.node_id};
    assign match   = (i_frame.can_id == resp_id)
                   && (i_frame.byte0 != deace_pkg::CS_WRITE_ACK)
                   && (i_frame.byte0 != deace_pkg::CS_ABORT);
    assign obj     = {i_frame.byte2, i_frame.byte1};

    assign is_acc_obj = (obj == deace_pkg::OBJ_PROFILE_ACC) || (obj == deace_pkg::OBJ_PROFILE_DEC)
                     || (obj == deace_pkg::OBJ_QSTOP_DEC) || (obj == deace_pkg::OBJ_MAX_ACC)
                     || (obj == deace_pkg::OBJ_MAX_DEC);

    // Keep only as many data bytes as the specifier announces
    always_comb begin
        case (i_frame.byte0)
            deace_pkg::CS_UPLOAD_1: data = {24'd0, i_frame.byte4};
            deace_pkg::CS_UPLOAD_2: data = {16'd0, i_frame.byte5, i_frame.byte4};
            deace_pkg::CS_UPLOAD_3: data = {8'd0, i_frame.byte6, i_frame.byte5, i_frame.byte4};
            deace_pkg::CS_UPLOAD_4: data = {i_frame.byte7, i_frame.byte6,
                                            i_frame.byte5, i_frame.byte4};
            default:                data = 32'd0;
        endcase
    end

    always_comb begin
        cur = i_state.current_code;
        tgt = i_state.target_code;
        o_result = '0;
        o_result.write_bytes = deace_pkg::WR_BYTES_WORD;

        if (match) begin
            if (obj == deace_pkg::OBJ_STATUS_WORD) begin
                cur = deace_pkg::classify(i_frame.byte4);
                if (i_frame.drive_enable) begin
                    // step the enable sequence once the drive has caught up
                    if (cur == tgt) begin
                        if (cur == deace_pkg::CODE_RTSO) begin
                            tgt = deace_pkg::CODE_SO;
                        end else if (cur == deace_pkg::CODE_SO) begin
                            tgt = deace_pkg::CODE_OE;
                        end else if (cur != deace_pkg::CODE_OE) begin
                            tgt = deace_pkg::CODE_RTSO;
                        end
                    end
                end else begin
                    tgt = deace_pkg::CODE_RTSO;
                end
                if (latched) begin
                    tgt = deace_pkg::CODE_RTSO;
                end
                if (cur != tgt) begin
                    o_result.send_write   = 1'b1;
                    o_result.write_object = deace_pkg::OBJ_CONTROL_WORD;
                    o_result.write_value  = {16'd0, deace_pkg::cw_for_state(tgt)};
                    o_result.write_bytes  = deace_pkg::WR_BYTES_CTRL;
                end
            end else if (obj == deace_pkg::OBJ_POSITION) begin
                o_result.encoder_valid = 1'b1;
                o_result.encoder_value = data;
            end else if (obj == deace_pkg::OBJ_HOME_OFFSET) begin
                if (data != 32'd0) begin
                    o_result.send_write   = 1'b1;
                    o_result.write_object = obj;
                    o_result.write_value  = i_cfg.home_offset_target;
                end
            end else if (obj == deace_pkg::OBJ_MOTION_PROF) begin
                if (data[15:0] != 16'd0) begin
                    o_result.send_write   = 1'b1;
                    o_result.write_object = obj;
                end
            end else if (obj == deace_pkg::OBJ_END_VELOCITY) begin
                if (data != 32'd0) begin
                    o_result.send_write   = 1'b1;
                    o_result.write_object = obj;
                end
            end else if (obj == deace_pkg::OBJ_PROFILE_VEL) begin
                if (data != i_cfg.prof_vel) begin
                    o_result.send_write   = 1'b1;
                    o_result.write_object = obj;
                    o_result.write_value  = i_cfg.prof_vel;
                end
            end else if (is_acc_obj) begin
                if (data != i_cfg.prof_acc) begin
                    o_result.send_write   = 1'b1;
                    o_result.write_object = obj;
                    o_result.write_value  = i_cfg.prof_acc;
                end
            end else if (obj == deace_pkg::OBJ_OP_MODE) begin
                if (data[7:0] != deace_pkg::OP_MODE_PROFILE_POS) begin
                    o_result.send_write   = 1'b1;
                    o_result.write_object = obj;
                    o_result.write_value  = {24'd0, deace_pkg::OP_MODE_PROFILE_POS};
                end
            end
        end

        o_result.drive_state   = cur;
        o_result.shutdown_done = latched && (cur == deace_pkg::CODE_RTSO);

        o_state.current_code     = cur;
        o_state.target_code      = tgt;
        o_state.shutdown_latched = latched;
    end

endmodule

@@ hw/rtl/drive_enable_and_config_enforcer.sv @@
// Top level: input register, drive state registers, configuration and result register.
//
//  channel   direction  handshake               payload
//  request   in         i_valid / o_stall       i_can_id, i_byte0..i_byte7, i_drive_enable,
//                                               i_shutdown_request
//  result    out        o_valid / i_stall       o_send_write .. o_shutdown_done
//  config    in         i_cfg_wen               i_cfg_idx, i_cfg_data
//
//  Each request passes through the input register, then through the decode into the result
//  register. One request per cycle is sustained while the result is not stalled; the drive
//  state registers update in the same cycle as the result register loads.
//  Synchronous active-low reset clears valids, the drive state (ready to switch on,
//  shutdown not latched) and the configuration (node id 112, others zero).
//  A stalled result holds the result register; the input register then fills and o_stall rises.
module drive_enable_and_config_enforcer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [deace_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [10:0]                         i_can_id,
    input  logic [7:0]                          i_byte0,
    input  logic [7:0]                          i_byte1,
    input  logic [7:0]                          i_byte2,
    input  logic [7:0]                          i_byte3,
    input  logic [7:0]                          i_byte4,
    input  logic [7:0]                          i_byte5,
    input  logic [7:0]                          i_byte6,
    input  logic [7:0]                          i_byte7,
    input  logic                                i_drive_enable,
    input  logic                                i_shutdown_request,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_send_write,
    output logic [15:0]                         o_write_object,
    output logic [31:0]                         o_write_value,
    output logic [2:0]                          o_write_bytes,
    output logic [2:0]                          o_drive_state,
    output logic                                o_encoder_valid,
    output logic signed [31:0]                  o_encoder_value,
    output logic                                o_shutdown_done
);

    deace_pkg::t_cfg    r_cfg;
    deace_pkg::t_frame  r_frame;
    logic               r_in_valid;
    deace_pkg::t_state  r_state;
    deace_pkg::t_state  n_state;
    deace_pkg::t_result r_result;
    deace_pkg::t_result n_result;
    logic               r_out_valid;
    logic               in_accept;
    logic               advance;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id            <= deace_pkg::NODE_ID_RESET;
            r_cfg.prof_vel           <= 32'd0;
            r_cfg.prof_acc           <= 32'd0;
            r_cfg.home_offset_target <= 32'd0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                deace_pkg::CFG_NODE_ID:     r_cfg.node_id            <= i_cfg_data[6:0];
                deace_pkg::CFG_PROFILE_VEL: r_cfg.prof_vel           <= i_cfg_data;
                deace_pkg::CFG_PROFILE_ACC: r_cfg.prof_acc           <= i_cfg_data;
                deace_pkg::CFG_HOME_OFFSET: r_cfg.home_offset_target <= i_cfg_data;
                default:                    r_cfg                    <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_frame.can_id           <= i_can_id;
            r_frame.byte0            <= i_byte0;
            r_frame.byte1            <= i_byte1;
            r_frame.byte2            <= i_byte2;
            r_frame.byte3            <= i_byte3;
            r_frame.byte4            <= i_byte4;
            r_frame.byte5            <= i_byte5;
            r_frame.byte6            <= i_byte6;
            r_frame.byte7            <= i_byte7;
            r_frame.drive_enable     <= i_drive_enable;
            r_frame.shutdown_request <= i_shutdown_request;
        end
    end

    deace_step u_step (
        .i_cfg    (r_cfg),
        .i_frame  (r_frame),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Drive state advances only with a request moving into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.current_code     <= deace_pkg::CODE_RTSO;
            r_state.target_code      <= deace_pkg::CODE_RTSO;
            r_state.shutdown_latched <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_send_write    = r_result.send_write;
    assign o_write_object  = r_result.write_object;
    assign o_write_value   = r_result.write_value;
    assign o_write_bytes   = r_result.write_bytes;
    assign o_drive_state   = r_result.drive_state;
    assign o_encoder_valid = r_result.encoder_valid;
    assign o_encoder_value = $signed(r_result.encoder_value);
    assign o_shutdown_done = r_result.shutdown_done;

`ifndef SYNTH
    a_done_means_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_shutdown_done) |-> (o_drive_state == deace_pkg::CODE_RTSO))
        else $error("shutdown done reported outside ready to switch on");

    a_ctrl_word_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send_write && (o_write_object == deace_pkg::OBJ_CONTROL_WORD))
        |-> (o_write_bytes == deace_pkg::WR_BYTES_CTRL))
        else $error("control word write with wrong length");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_encoder_valid) |-> !o_send_write)
        else $error("position reply also asks for a write");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("drive state changed without a request");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held request lost from input register");
`endif

endmodule

@@ test/drive_enable_and_config_enforcer_test.sv @@
// Self-checking testbench for the CiA 402 drive enable and configuration enforcer.
`timescale 1ns / 1ps

module drive_enable_and_config_enforcer_test;
    import deace_pkg::*;

    localparam int STUCK_LIMIT  = 3000;
    localparam int HOLD_AFTER   = 1300;
    localparam int HOLD_CYCLES  = 80;

    localparam logic [15:0] CFG_OBJS [10] = '{OBJ_HOME_OFFSET, OBJ_MOTION_PROF,
        OBJ_END_VELOCITY, OBJ_PROFILE_VEL, OBJ_PROFILE_ACC, OBJ_PROFILE_DEC,
        OBJ_QSTOP_DEC, OBJ_MAX_ACC, OBJ_MAX_DEC, OBJ_OP_MODE};
    localparam logic [7:0] UPLOAD_CS [4] = '{CS_UPLOAD_1, CS_UPLOAD_2, CS_UPLOAD_3,
        CS_UPLOAD_4};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_NODE_ID;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [10:0]          i_can_id = '0;
    logic [7:0]           i_byte0 = '0;
    logic [7:0]           i_byte1 = '0;
    logic [7:0]           i_byte2 = '0;
    logic [7:0]           i_byte3 = '0;
    logic [7:0]           i_byte4 = '0;
    logic [7:0]           i_byte5 = '0;
    logic [7:0]           i_byte6 = '0;
    logic [7:0]           i_byte7 = '0;
    logic                 i_drive_enable = 1'b0;
    logic                 i_shutdown_request = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_send_write;
    logic [15:0]          o_write_object;
    logic [31:0]          o_write_value;
    logic [2:0]           o_write_bytes;
    logic [2:0]           o_drive_state;
    logic                 o_encoder_valid;
    logic signed [31:0]   o_encoder_value;
    logic                 o_shutdown_done;

    drive_enable_and_config_enforcer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wen          (i_cfg_wen),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_can_id           (i_can_id),
        .i_byte0            (i_byte0),
        .i_byte1            (i_byte1),
        .i_byte2            (i_byte2),
        .i_byte3            (i_byte3),
        .i_byte4            (i_byte4),
        .i_byte5            (i_byte5),
        .i_byte6            (i_byte6),
        .i_byte7            (i_byte7),
        .i_drive_enable     (i_drive_enable),
        .i_shutdown_request (i_shutdown_request),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_send_write       (o_send_write),
        .o_write_object     (o_write_object),
        .o_write_value      (o_write_value),
        .o_write_bytes      (o_write_bytes),
        .o_drive_state      (o_drive_state),
        .o_encoder_valid    (o_encoder_valid),
        .o_encoder_value    (o_encoder_value),
        .o_shutdown_done    (o_shutdown_done)
    );

    always #10 i_clk = ~i_clk;

    // Drive model state and wanted configuration
    t_code   drive_now = CODE_RTSO;
    t_code   drive_goal = CODE_RTSO;
    logic    stop_latched = 1'b0;
    t_cfg    wanted = '{node_id: NODE_ID_RESET, default: '0};

    t_frame  frames_to_send [$];
    t_result predicted_actions [$];
    t_frame  frame_on_bus;
    int      frames_queued = 0;
    int      frames_taken = 0;
    int      actions_seen = 0;
    int      fault_count = 0;
    int      stuck_cycles = 0;
    int      hold_left = 0;
    int      send_gap_pct = 19;
    int      recv_stall_pct = 75;

    function automatic t_code decode_status(logic [15:0] sw);
        if ((sw & 16'h004F) == 16'h0000) return CODE_NRTSO;
        if ((sw & 16'h006F) == 16'h0007) return CODE_QSA;
        if ((sw & 16'h004F) == 16'h000F) return CODE_FRA;
        if ((sw & 16'h006F) == 16'h0021) return CODE_RTSO;
        if ((sw & 16'h006F) == 16'h0023) return CODE_SO;
        if ((sw & 16'h006F) == 16'h0027) return CODE_OE;
        if ((sw & 16'h004F) == 16'h0040) return CODE_SOD;
        return CODE_F;
    endfunction

    function automatic logic [31:0] drive_command(t_code goal);
        case (goal)
            CODE_RTSO: return 32'd6;
            CODE_SO:   return 32'd7;
            CODE_OE:   return 32'd15;
            default:   return 32'd0;
        endcase
    endfunction

    // Work out the reply to one frame and advance the drive model
    function automatic t_result predict_action(t_frame f);
        t_result     r;
        logic [15:0] obj;
        logic [31:0] data;
        r = '0;
        r.write_bytes = WR_BYTES_WORD;
        if (f.shutdown_request) stop_latched = 1'b1;
        if (f.can_id == SDO_RESP_BASE + 11'(wanted.node_id)
                && f.byte0 != CS_WRITE_ACK && f.byte0 != CS_ABORT) begin
            obj = {f.byte2, f.byte1};
            case (f.byte0)
                CS_UPLOAD_1: data = {24'd0, f.byte4};
                CS_UPLOAD_2: data = {16'd0, f.byte5, f.byte4};
                CS_UPLOAD_3: data = {8'd0, f.byte6, f.byte5, f.byte4};
                CS_UPLOAD_4: data = {f.byte7, f.byte6, f.byte5, f.byte4};
                default:     data = '0;
            endcase
            case (obj)
                OBJ_STATUS_WORD: begin
                    drive_now = decode_status({f.byte5, f.byte4});
                    if (!f.drive_enable) begin
                        drive_goal = CODE_RTSO;
                    end else if (drive_now == drive_goal) begin
                        case (drive_now)
                            CODE_RTSO: drive_goal = CODE_SO;
                            CODE_SO:   drive_goal = CODE_OE;
                            CODE_OE:   ;
                            default:   drive_goal = CODE_RTSO;
                        endcase
                    end
                    if (stop_latched) drive_goal = CODE_RTSO;
                    if (drive_now != drive_goal) begin
                        r.send_write = 1'b1;
                        r.write_object = OBJ_CONTROL_WORD;
                        r.write_value = drive_command(drive_goal);
                        r.write_bytes = WR_BYTES_CTRL;
                    end
                end
                OBJ_POSITION: begin
                    r.encoder_valid = 1'b1;
                    r.encoder_value = data;
                end
                OBJ_HOME_OFFSET: begin
                    r.send_write = (data != 0);
                    r.write_value = wanted.home_offset_target;
                end
                OBJ_MOTION_PROF:  r.send_write = (data[15:0] != 0);
                OBJ_END_VELOCITY: r.send_write = (data != 0);
                OBJ_PROFILE_VEL: begin
                    r.send_write = (data != wanted.prof_vel);
                    r.write_value = wanted.prof_vel;
                end
                OBJ_PROFILE_ACC, OBJ_PROFILE_DEC, OBJ_QSTOP_DEC, OBJ_MAX_ACC,
                OBJ_MAX_DEC: begin
                    r.send_write = (data != wanted.prof_acc);
                    r.write_value = wanted.prof_acc;
                end
                OBJ_OP_MODE: begin
                    r.send_write = (data[7:0] != OP_MODE_PROFILE_POS);
                    r.write_value = 32'(OP_MODE_PROFILE_POS);
                end
                default: ;
            endcase
            if (obj != OBJ_STATUS_WORD) begin
                if (r.send_write) r.write_object = obj;
                else r.write_value = '0;
            end
        end
        r.drive_state = drive_now;
        r.shutdown_done = stop_latched && drive_now == CODE_RTSO;
        return r;
    endfunction

    function automatic logic [7:0] pick_cs();
        if ($urandom_range(9) < 8) return UPLOAD_CS[$urandom_range(3)];
        return 8'($urandom_range(255));
    endfunction

    function automatic t_frame sdo_reply(logic [7:0] cs, logic [15:0] obj,
                                         logic [31:0] value, bit en, bit stop);
        t_frame f;
        f.can_id = SDO_RESP_BASE + 11'(wanted.node_id);
        f.byte0 = cs;
        {f.byte2, f.byte1} = obj;
        f.byte3 = 8'($urandom_range(255));
        {f.byte7, f.byte6, f.byte5, f.byte4} = value;
        f.drive_enable = en;
        f.shutdown_request = stop;
        return f;
    endfunction

    // Status reply whose word carries the pattern of the given state, other bits random
    function automatic t_frame status_reply(t_code k, bit en, bit stop);
        logic [31:0] w;
        w = $urandom;
        w[7:0] = (w[7:0] & ~CLS_MASK[k]) | CLS_ID[k];
        return sdo_reply(pick_cs(), OBJ_STATUS_WORD, w, en, stop);
    endfunction

    function automatic logic [31:0] wanted_value(logic [15:0] obj);
        case (obj)
            OBJ_PROFILE_VEL: return wanted.prof_vel;
            OBJ_PROFILE_ACC, OBJ_PROFILE_DEC, OBJ_QSTOP_DEC, OBJ_MAX_ACC,
            OBJ_MAX_DEC:     return wanted.prof_acc;
            OBJ_OP_MODE:     return 32'(OP_MODE_PROFILE_POS);
            OBJ_MOTION_PROF: return {16'($urandom_range(65535)), 16'd0};
            default:         return '0;
        endcase
    endfunction

    task automatic push_frame(input t_frame f);
        frames_to_send.push_back(f);
        frames_queued++;
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            CFG_NODE_ID:     wanted.node_id = value[6:0];
            CFG_PROFILE_VEL: wanted.prof_vel = value;
            CFG_PROFILE_ACC: wanted.prof_acc = value;
            CFG_HOME_OFFSET: wanted.home_offset_target = value;
            default: ;
        endcase
    endtask

    task automatic set_all_registers(input logic [6:0] node, input logic [31:0] vel,
                                     input logic [31:0] acc, input logic [31:0] home);
        set_register(CFG_NODE_ID, 32'(node));
        set_register(CFG_PROFILE_VEL, vel);
        set_register(CFG_PROFILE_ACC, acc);
        set_register(CFG_HOME_OFFSET, home);
    endtask

    // Hold until every queued request is taken and every reply has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (frames_taken != frames_queued || predicted_actions.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_directed_frames();
        t_frame f;
        // enable sequence, then disable
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0021, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0023, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0027, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_FF37, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0027, 1'b0, 1'b0));
        // the remaining states, plus words that match no pattern and fall back to fault
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0000, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0008, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_4, OBJ_STATUS_WORD, 32'hFFFF_FFFF, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0007, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_000F, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0040, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0048, 1'b1, 1'b0));
        // foreign identifiers, write acknowledge and abort
        f = sdo_reply(CS_UPLOAD_2, OBJ_STATUS_WORD, 32'h0000_0021, 1'b1, 1'b0);
        f.can_id = 11'h000;
        push_frame(f);
        f.can_id = 11'h7FF;
        push_frame(f);
        push_frame(sdo_reply(CS_WRITE_ACK, OBJ_STATUS_WORD, 32'h0000_0021, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_ABORT, OBJ_STATUS_WORD, 32'h0000_0021, 1'b1, 1'b0));
        // position at four-byte and one-byte lengths, and an unknown specifier that yields zero data
        push_frame(sdo_reply(CS_UPLOAD_4, OBJ_POSITION, 32'h8000_0000, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_1, OBJ_POSITION, 32'hFFFF_FFFF, 1'b1, 1'b0));
        push_frame(sdo_reply(8'h00, OBJ_POSITION, 32'h7FFF_FFFF, 1'b1, 1'b0));
        // configuration objects, matching and differing
        push_frame(sdo_reply(CS_UPLOAD_4, OBJ_HOME_OFFSET, 32'h0000_0001, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_4, OBJ_MOTION_PROF, 32'h0001_0000, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_2, OBJ_END_VELOCITY, 32'h0000_0005, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_4, OBJ_PROFILE_VEL, 32'h0000_0000, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_3, OBJ_MAX_DEC, 32'hFF12_3456, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_1, OBJ_OP_MODE, 32'hFFFF_FF01, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_1, OBJ_OP_MODE, 32'h0000_0002, 1'b1, 1'b0));
        push_frame(sdo_reply(CS_UPLOAD_4, 16'h1234, 32'hDEAD_BEEF, 1'b1, 1'b0));
    endtask

    // Mostly enable sequences and configuration replies, the rest noise
    task automatic queue_random_frames(input int count, input bit allow_stop);
        int          added;
        int          r;
        int          extra;
        bit          stop;
        logic [15:0] obj;
        logic [31:0] value;
        t_frame      f;
        added = 0;
        while (added < count) begin
            r = $urandom_range(99);
            stop = allow_stop && ($urandom_range(19) == 0);
            if (r < 40) begin
                push_frame(status_reply(CODE_RTSO, 1'b1, stop));
                push_frame(status_reply(CODE_SO, 1'b1, 1'b0));
                push_frame(status_reply(CODE_OE, 1'b1, 1'b0));
                added += 3;
                extra = $urandom_range(3);
                repeat (extra) begin
                    if ($urandom_range(1))
                        push_frame(status_reply(CODE_OE, 1'b1, 1'b0));
                    else
                        push_frame(sdo_reply(pick_cs(), OBJ_POSITION, $urandom, 1'b1, 1'b0));
                    added++;
                end
            end else if (r < 65) begin
                obj = CFG_OBJS[$urandom_range(9)];
                value = $urandom_range(1) ? wanted_value(obj) : $urandom;
                push_frame(sdo_reply($urandom_range(2) ? CS_UPLOAD_4 : pick_cs(), obj, value,
                                     1'($urandom_range(1)), stop));
                added++;
            end else if (r < 75) begin
                push_frame(sdo_reply(pick_cs(), OBJ_POSITION, $urandom,
                                     1'($urandom_range(1)), stop));
                added++;
            end else if (r < 85) begin
                push_frame(sdo_reply(pick_cs(), OBJ_STATUS_WORD, $urandom,
                                     1'($urandom_range(1)), stop));
                added++;
            end else if (r < 93) begin
                f = t_frame'({$urandom, $urandom, $urandom});
                f.shutdown_request = stop;
                push_frame(f);
                added++;
            end else begin
                case ($urandom_range(2))
                    0:       f = sdo_reply(CS_WRITE_ACK, OBJ_STATUS_WORD, $urandom, 1'b1, stop);
                    1:       f = sdo_reply(CS_ABORT, CFG_OBJS[$urandom_range(9)], $urandom,
                                           1'b1, stop);
                    default: f = sdo_reply(pick_cs(), 16'($urandom_range(65535)), $urandom,
                                           1'($urandom_range(1)), stop);
                endcase
                push_frame(f);
                added++;
            end
        end
    endtask

    // Request driver: predict on acceptance, then offer the next frame or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predicted_actions.push_back(predict_action(frame_on_bus));
                frames_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (frames_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    frame_on_bus = frames_to_send.pop_front();
                    i_can_id <= frame_on_bus.can_id;
                    i_byte0 <= frame_on_bus.byte0;
                    i_byte1 <= frame_on_bus.byte1;
                    i_byte2 <= frame_on_bus.byte2;
                    i_byte3 <= frame_on_bus.byte3;
                    i_byte4 <= frame_on_bus.byte4;
                    i_byte5 <= frame_on_bus.byte5;
                    i_byte6 <= frame_on_bus.byte6;
                    i_byte7 <= frame_on_bus.byte7;
                    i_drive_enable <= frame_on_bus.drive_enable;
                    i_shutdown_request <= frame_on_bus.shutdown_request;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fault_count++;
            $display("%0t %s: expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Result monitor and stall driver
    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                actions_seen++;
                if (predicted_actions.size() == 0) begin
                    fault_count++;
                    $display("%0t result: expected none actual send %b obj %h state %0d",
                             $time, o_send_write, o_write_object, o_drive_state);
                end else begin
                    want = predicted_actions.pop_front();
                    compare_field("send_write", 32'(want.send_write), 32'(o_send_write));
                    compare_field("write_object", 32'(want.write_object), 32'(o_write_object));
                    compare_field("write_value", want.write_value, o_write_value);
                    compare_field("write_bytes", 32'(want.write_bytes), 32'(o_write_bytes));
                    compare_field("drive_state", 32'(want.drive_state), 32'(o_drive_state));
                    compare_field("encoder_valid", 32'(want.encoder_valid),
                                  32'(o_encoder_valid));
                    compare_field("encoder_value", want.encoder_value, o_encoder_value);
                    compare_field("shutdown_done", 32'(want.shutdown_done),
                                  32'(o_shutdown_done));
                end
                // long hold-off so the block fills and stalls its input
                if (actions_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("drive_enable_and_config_enforcer: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_directed_frames();
        wait_drained();

        set_all_registers(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_random_frames(500, 1'b0);
        wait_drained();

        send_gap_pct = 75;
        recv_stall_pct = 19;
        set_all_registers(7'd1, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        queue_random_frames(500, 1'b0);
        wait_drained();

        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_all_registers(7'd0, $urandom, $urandom, $urandom);
        queue_random_frames(250, 1'b0);
        wait_drained();
        set_all_registers(7'($urandom_range(127, 1)), $urandom, $urandom, $urandom);
        queue_random_frames(250, 1'b0);
        wait_drained();

        // shutdown latches until reset, so keep it for the last stretch
        set_register(CFG_NODE_ID, 32'($urandom_range(127, 1)));
        queue_random_frames(200, 1'b1);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("drive_enable_and_config_enforcer: match");
        end else begin
            $display("drive_enable_and_config_enforcer: mismatch");
        end
        $finish;
    end

endmodule
